@@ rtl/rrelp_pkg.sv @@
`timescale 1ns / 1ps

package rrelp_pkg;

   // line store size and the column counter that follows from it
   localparam int LINE_STORE = 256;
   localparam int COL_W      = $clog2(LINE_STORE + 1);
   localparam int CMP_W      = ((COL_W > 9) ? COL_W : 9) + 1;

   localparam int PAYLOAD_COL  = 34;
   localparam int ROUTE_MAX    = 63;
   localparam int NUM_FIELDS   = 6;
   localparam int NUM_IDS      = 4;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;

   // header field windows: origin, destination, message id, selector, RSSI, length
   localparam int FIELD_START [NUM_FIELDS] = '{7, 13, 18, 23, 28, 31};
   localparam int FIELD_LEN   [NUM_FIELDS] = '{4, 4, 4, 4, 2, 2};

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ROUTE   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one classified event from the front end; a summary may carry a route
   // token that must be emitted ahead of it
   typedef struct packed {
      logic [1:0]  kind;
      logic        pre_route;
      logic [15:0] value;
      logic [15:0] origin_id;
      logic [15:0] destination_id;
      logic [15:0] message_number;
      logic [15:0] selector_value;
      logic [7:0]  signal_strength;
      logic [7:0]  payload_length;
      logic [5:0]  route_total;
   } event_type;

endpackage

@@ rtl/rrelp_front.sv @@
`timescale 1ns / 1ps

module rrelp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          rx_byte,
   output logic                push,
   output rrelp_pkg::event_type push_event
);
   import rrelp_pkg::*;

   // decode one hex digit: bit 4 flags a valid digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   logic [COL_W-1:0]      column_ff, column_in;
   logic [7:0]            held_char_ff, held_char_in;
   logic                  held_valid_ff, held_valid_in;
   logic [15:0]           ids_ff [NUM_IDS];
   logic [15:0]           ids_in [NUM_IDS];
   logic [7:0]            rssi_ff, rssi_in;
   logic [7:0]            len_ff, len_in;
   logic [NUM_FIELDS-1:0] stopped_ff, stopped_in;
   logic [15:0]           raccum_ff, raccum_in;
   logic                  ropen_ff, ropen_in;
   logic                  rstop_ff, rstop_in;
   logic [5:0]            rcount_ff, rcount_in;

   logic                  eol;
   logic                  commit;
   logic [CMP_W-1:0]      pos;
   logic [CMP_W-1:0]      pay_end;
   logic [4:0]            hex;
   logic [5:0]            rcount_inc;
   logic                  in_win;

   always_comb begin
      eol        = (rx_byte == NEWLINE_CHAR) || (column_ff >= COL_W'(LINE_STORE - 1));
      commit     = held_valid_ff && (column_ff != '0);
      pos        = CMP_W'(column_ff - COL_W'(1));
      pay_end    = CMP_W'(PAYLOAD_COL) + CMP_W'(len_ff);
      hex        = hex_decode(held_char_ff);
      rcount_inc = (rcount_ff != 6'(ROUTE_MAX)) ? rcount_ff + 6'd1 : rcount_ff;
      in_win     = 1'b0;

      column_in     = column_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      for (int i = 0; i < NUM_IDS; i++) ids_in[i] = ids_ff[i];
      rssi_in    = rssi_ff;
      len_in     = len_ff;
      stopped_in = stopped_ff;
      raccum_in  = raccum_ff;
      ropen_in   = ropen_ff;
      rstop_in   = rstop_ff;
      rcount_in  = rcount_ff;

      push       = 1'b0;
      push_event = '0;

      if (take) begin
         if (eol) begin
            // close any open token, report the line, clear per-line state
            push                      = 1'b1;
            push_event.kind           = KIND_SUMMARY;
            push_event.pre_route      = ropen_ff;
            push_event.value          = raccum_ff;
            push_event.origin_id      = ids_ff[0];
            push_event.destination_id = ids_ff[1];
            push_event.message_number = ids_ff[2];
            push_event.selector_value = ids_ff[3];
            push_event.signal_strength = rssi_ff;
            push_event.payload_length = len_ff;
            push_event.route_total    = ropen_ff ? rcount_inc : rcount_ff;
            column_in     = '0;
            held_char_in  = '0;
            held_valid_in = 1'b0;
            for (int i = 0; i < NUM_IDS; i++) ids_in[i] = '0;
            rssi_in    = '0;
            len_in     = '0;
            stopped_in = '0;
            raccum_in  = '0;
            ropen_in   = 1'b0;
            rstop_in   = 1'b0;
            rcount_in  = '0;
         end else begin
            if (commit) begin
               // header windows are disjoint, so each field updates alone
               for (int f = 0; f < NUM_FIELDS; f++) begin
                  in_win = (pos >= CMP_W'(FIELD_START[f])) &&
                           (pos < CMP_W'(FIELD_START[f] + FIELD_LEN[f]));
                  if (in_win && !stopped_ff[f]) begin
                     if (!hex[4]) begin
                        stopped_in[f] = 1'b1;
                     end else if (f < NUM_IDS) begin
                        ids_in[f] = {ids_ff[f][11:0], hex[3:0]};
                     end else if (f == NUM_IDS) begin
                        rssi_in = {rssi_ff[3:0], hex[3:0]};
                     end else begin
                        len_in = {len_ff[3:0], hex[3:0]};
                     end
                  end
               end
               if (pos >= CMP_W'(PAYLOAD_COL) && pos < pay_end) begin
                  push             = 1'b1;
                  push_event.kind  = KIND_PAYLOAD;
                  push_event.value = {8'h00, held_char_ff};
               end else if (pos > pay_end) begin
                  if (held_char_ff == SPACE_CHAR) begin
                     if (ropen_ff) begin
                        push             = 1'b1;
                        push_event.kind  = KIND_ROUTE;
                        push_event.value = raccum_ff;
                        rcount_in = rcount_inc;
                        ropen_in  = 1'b0;
                        rstop_in  = 1'b0;
                        raccum_in = '0;
                     end
                  end else begin
                     ropen_in = 1'b1;
                     if (!ropen_ff || !rstop_ff) begin
                        if (!hex[4]) begin
                           rstop_in  = 1'b1;
                           raccum_in = ropen_ff ? raccum_ff : 16'h0000;
                        end else begin
                           rstop_in  = 1'b0;
                           raccum_in = ropen_ff ? {raccum_ff[11:0], hex[3:0]}
                                                : {12'h000, hex[3:0]};
                        end
                     end
                  end
               end
            end
            held_char_in  = rx_byte;
            held_valid_in = 1'b1;
            column_in     = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_IDS; i++) ids_ff[i] <= '0;
         rssi_ff    <= '0;
         len_ff     <= '0;
         stopped_ff <= '0;
         raccum_ff  <= '0;
         ropen_ff   <= 1'b0;
         rstop_ff   <= 1'b0;
         rcount_ff  <= '0;
      end else begin
         column_ff     <= column_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         for (int i = 0; i < NUM_IDS; i++) ids_ff[i] <= ids_in[i];
         rssi_ff    <= rssi_in;
         len_ff     <= len_in;
         stopped_ff <= stopped_in;
         raccum_ff  <= raccum_in;
         ropen_ff   <= ropen_in;
         rstop_ff   <= rstop_in;
         rcount_ff  <= rcount_in;
      end
   end

endmodule

@@ rtl/rrelp_queue.sv @@
`timescale 1ns / 1ps

module rrelp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rrelp_pkg::event_type push_event,
   input  logic                 pop,
   output rrelp_pkg::event_type head,
   output logic                 empty,
   output logic                 full
);
   import rrelp_pkg::*;

   event_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head     = slot_ff[rd_ff];
      wr_in    = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/rrelp_back.sv @@
`timescale 1ns / 1ps

module rrelp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rrelp_pkg::event_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [15:0]          rsp_value,
   output logic [15:0]          rsp_origin_id,
   output logic [15:0]          rsp_destination_id,
   output logic [15:0]          rsp_message_number,
   output logic [15:0]          rsp_selector_value,
   output logic [7:0]           rsp_signal_strength,
   output logic [7:0]           rsp_payload_length,
   output logic [5:0]           rsp_route_total,
   output logic                 rsp_last
);
   import rrelp_pkg::*;

   logic      valid_ff, valid_in;
   logic      phase_ff, phase_in;
   logic      load;
   event_type word_ff, word_in;
   logic      last_ff, last_in;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      valid_in = valid_ff;
      phase_in = phase_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            if (head.pre_route && !phase_ff) begin
               // emit the token that closed with the line, summary next
               word_in       = '0;
               word_in.kind  = KIND_ROUTE;
               word_in.value = head.value;
               last_in       = 1'b0;
               phase_in      = 1'b1;
            end else begin
               word_in = head;
               if (head.kind == KIND_SUMMARY) word_in.value = '0;
               last_in  = 1'b1;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = word_ff.kind;
   assign rsp_value           = word_ff.value;
   assign rsp_origin_id       = word_ff.origin_id;
   assign rsp_destination_id  = word_ff.destination_id;
   assign rsp_message_number  = word_ff.message_number;
   assign rsp_selector_value  = word_ff.selector_value;
   assign rsp_signal_strength = word_ff.signal_strength;
   assign rsp_payload_length  = word_ff.payload_length;
   assign rsp_route_total     = word_ff.route_total;
   assign rsp_last            = last_ff;

endmodule

@@ rtl/radio_rx_event_line_parser.sv @@
`timescale 1ns / 1ps
// Receive-event line parser for a radio module serial link.
// Input channel (req_): one received character per word on req_rx_byte,
// taken when req_valid is high and req_stall is low.
// Result channel (rsp_): payload bytes, route ids and one end-of-line
// summary per line, each word with rsp_kind, rsp_value, the header fields
// and rsp_last marking the final result caused by one input character.
// Throughput: one character per cycle while req_stall is low. A character
// yields at most one result, except a line end inside a route token,
// which yields two that take the result port one after the other.
// Results pass from the front end parse into the event queue, then
// through the output register.
// Every character is held back by one place so that the carriage return
// before the newline can be dropped.
// When the receiver holds rsp_stall, the output word holds and the event
// queue (four entries) fills; once it is full req_stall rises.
// Reset clears the line state, the queue and the output valid.
module radio_rx_event_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_value,
   output logic [15:0] rsp_origin_id,
   output logic [15:0] rsp_destination_id,
   output logic [15:0] rsp_message_number,
   output logic [15:0] rsp_selector_value,
   output logic [7:0]  rsp_signal_strength,
   output logic [7:0]  rsp_payload_length,
   output logic [5:0]  rsp_route_total,
   output logic        rsp_last
);
   import rrelp_pkg::*;

   logic      take;
   logic      push;
   event_type push_event;
   event_type head;
   logic      empty;
   logic      full;
   logic      pop;

   // accept a character whenever the queue has room for its event
   assign req_stall = full;
   assign take      = req_valid && !full;

   // front end: column tracking, header fields, payload and route tokens
   rrelp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_rx_byte),
      .push       (push),
      .push_event (push_event)
   );

   // decouple parsing from the result port
   rrelp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   // back end: expand events into result words, drive the output register
   rrelp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .empty               (empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_value           (rsp_value),
      .rsp_origin_id       (rsp_origin_id),
      .rsp_destination_id  (rsp_destination_id),
      .rsp_message_number  (rsp_message_number),
      .rsp_selector_value  (rsp_selector_value),
      .rsp_signal_strength (rsp_signal_strength),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_route_total     (rsp_route_total),
      .rsp_last            (rsp_last)
   );

endmodule
